// File: src/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the chained hash table
// Field widths, default sizing, actions, status codes, sequencer states and the remainder unit status.
// ----------------------------------------------------------------------------
package cht_pkg;

  // Field widths
  localparam int KEY_W   = 31;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 5;
  localparam int STAT_W  = 2;

  // Default sizing of the table
  localparam int MAX_BUCKETS_DEF = 16;
  localparam int CHAIN_DEPTH_DEF = 8;

  // Bucket count after reset
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = CFG_W'(10);

  // Remainder unit: one hex digit of the key per cycle
  localparam int DIG_W = 4;
  localparam int NDIG  = (KEY_W + DIG_W - 1) / DIG_W;
  localparam int NUM_W = DIG_W * NDIG;
  localparam int DCW   = (NDIG > 1) ? $clog2(NDIG) : 1;

  // Input operation
  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } cht_action_e;

  // Result status
  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } cht_status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_LEN,
    S_CHECK,
    S_SCAN,
    S_DONE
  } cht_state_e;

  // Remainder unit status
  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] rem;
  } cht_div_t;

endpackage

// File: src/cht_mod.sv
// ----------------------------------------------------------------------------
// cht_mod: iterative key modulo bucket count
// Restoring remainder, four key bits per cycle, done pulses with the bucket.
// ----------------------------------------------------------------------------
module cht_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cht_pkg::KEY_W-1:0] dividend_i,
  input  logic [cht_pkg::CFG_W-1:0] divisor_i,
  output cht_pkg::cht_div_t         div_o
);
  import cht_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [DCW-1:0]   cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [CFG_W-1:0] rem_q, rem_d;
  logic [CFG_W-1:0] dsr_q;

  // Fold the next digit into the partial remainder, bit by bit
  always_comb begin
    logic [CFG_W:0] t;
    rem_d = rem_q;
    for (int i = 0; i < DIG_W; i++) begin
      t = {rem_d, num_q[NUM_W-1-i]};
      if (t >= {1'b0, dsr_q}) begin
        t = t - {1'b0, dsr_q};
      end
      rem_d = t[CFG_W-1:0];
    end
  end

  // Sequence the digits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DCW'(1);
        if (cnt_q == DCW'(NDIG - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= NUM_W'(dividend_i);
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_q << DIG_W;
      rem_q <= rem_d;
    end
  end

  assign div_o.done = done_q;
  assign div_o.rem  = rem_q;

endmodule

// File: src/chained_hash_table_top.sv
// ----------------------------------------------------------------------------
// chained_hash_table_top: key/value table with separate chaining
// Bucket is key modulo the bucket count; insert appends unless the chain is
// full, search returns the oldest matching entry of the bucket.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                        tuser
//  s_axis    in         [30:0] key, [62:31] value    [0] action
//  m_axis    out        [31:0] found_value           [1:0] status
//  cfg       in         cfg_wdata_i bucket_count     -
//
//  After a request is accepted the sequencer waits for the eight-digit
//  remainder unit, reads the chain length and, for a search, scans the chain
//  through the single read port of the entry memory; the next request is
//  taken in the cycle after the result is loaded.
//  After reset a clearing pass zeroes the chain lengths of all MAX_BUCKETS
//  buckets; no request is taken meanwhile, configuration writes are.
//  A finished result waits in the output register while the next request
//  is accepted; a held result stalls only the sequencer at its end.
// ----------------------------------------------------------------------------
module chained_hash_table_top #(
  parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF,
  parameter int CHAIN_DEPTH = cht_pkg::CHAIN_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // [30:0] key, [62:31] value, [63] zero
  input  logic [63:0]                s_axis_tdata,
  // [0] action
  input  logic                       s_axis_tuser,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [31:0] found_value
  output logic [31:0]                m_axis_tdata,
  // [1:0] status
  output logic [1:0]                 m_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic                       cfg_we_i,
  input  logic [cht_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import cht_pkg::*;

  localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SLOTS = MAX_BUCKETS * CHAIN_DEPTH;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW    = $clog2(CHAIN_DEPTH + 1);
  localparam int JW    = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;

  // Storage
  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];
  logic [LW-1:0]    len_mem [MAX_BUCKETS];

  cht_state_e       state_q, state_d;
  logic [CFG_W-1:0] cfg_q;
  logic [CFG_W-1:0] eff_div;
  logic [BW-1:0]    clr_q;
  logic             clr_last;

  logic             act_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [BW-1:0]    bucket_q;
  logic [SW-1:0]    base_q;
  logic [LW-1:0]    len_rd_q;
  logic [JW-1:0]    j_q, j_d;
  logic [KEY_W-1:0] key_rd_q;
  logic [VAL_W-1:0] val_rd_q;

  cht_status_e      res_status_q, res_status_d;
  logic [VAL_W-1:0] res_value_q, res_value_d;
  logic             res_load;

  logic             m_valid_q;
  logic [VAL_W-1:0] m_data_q;
  cht_status_e      m_status_q;

  logic             accept;
  logic             len_we, len_rd_en, slot_we, slot_rd_en, out_load;
  logic [BW-1:0]    len_waddr;
  logic [LW-1:0]    len_wdata;
  logic [SW-1:0]    slot_rd_addr, slot_wr_addr;
  logic             len_full, scan_hit, scan_last;

  cht_div_t         div;

  // Effective divisor: zero counts as one, saturate at the bucket limit
  always_comb begin
    if (cfg_q == '0) begin
      eff_div = CFG_W'(1);
    end else if (int'(cfg_q) > MAX_BUCKETS) begin
      eff_div = CFG_W'(MAX_BUCKETS);
    end else begin
      eff_div = cfg_q;
    end
  end

  cht_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (s_axis_tdata[KEY_W-1:0]),
    .divisor_i  (eff_div),
    .div_o      (div)
  );

  assign accept       = s_axis_tvalid && s_axis_tready;
  assign clr_last     = (clr_q == BW'(MAX_BUCKETS - 1));
  assign len_full     = (len_rd_q >= LW'(CHAIN_DEPTH));
  assign scan_hit     = (key_rd_q == key_q);
  assign scan_last    = ((LW'(j_q) + LW'(1)) == len_rd_q);
  assign slot_wr_addr = base_q + SW'(len_rd_q);
  assign slot_rd_addr = base_q + SW'(j_d);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_last) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_HASH;
      S_HASH:  if (div.done) state_d = S_LEN;
      S_LEN:   state_d = S_CHECK;
      S_CHECK: begin
        if (act_q == ACT_INSERT || len_rd_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN:  if (scan_hit || scan_last) state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    len_we        = 1'b0;
    len_waddr     = bucket_q;
    len_wdata     = len_rd_q + LW'(1);
    len_rd_en     = 1'b0;
    slot_we       = 1'b0;
    slot_rd_en    = 1'b0;
    j_d           = '0;
    res_load      = 1'b0;
    res_status_d  = ST_NOT_FOUND;
    res_value_d   = '0;
    out_load      = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        len_we    = 1'b1;
        len_waddr = clr_q;
        len_wdata = '0;
      end
      S_IDLE: s_axis_tready = 1'b1;
      S_HASH: ;
      S_LEN:  len_rd_en = 1'b1;
      S_CHECK: begin
        if (act_q == ACT_INSERT) begin
          res_load = 1'b1;
          if (len_full) begin
            res_status_d = ST_FULL;
          end else begin
            res_status_d = ST_INSERTED;
            slot_we      = 1'b1;
            len_we       = 1'b1;
          end
        end else if (len_rd_q == '0) begin
          res_load = 1'b1;
        end else begin
          slot_rd_en = 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          res_load     = 1'b1;
          res_status_d = ST_FOUND;
          res_value_d  = val_rd_q;
        end else if (scan_last) begin
          res_load = 1'b1;
        end else begin
          j_d        = j_q + JW'(1);
          slot_rd_en = 1'b1;
        end
      end
      S_DONE: out_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cfg_q     <= BUCKET_COUNT_RST;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (state_q == S_CLEAR) clr_q <= clr_q + BW'(1);
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Request, bucket and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= s_axis_tuser;
      key_q <= s_axis_tdata[KEY_W-1:0];
      val_q <= s_axis_tdata[KEY_W +: VAL_W];
    end
    if (state_q == S_HASH && div.done) begin
      bucket_q <= BW'(div.rem);
      base_q   <= SW'(int'(BW'(div.rem)) * CHAIN_DEPTH);
    end
    if (state_q == S_CHECK || state_q == S_SCAN) j_q <= j_d;
    if (res_load) begin
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
    end
    if (out_load) begin
      m_status_q <= res_status_q;
      m_data_q   <= res_value_q;
    end
  end

  // Chain length memory
  always_ff @(posedge clk_i) begin
    if (len_we) len_mem[len_waddr] <= len_wdata;
    if (len_rd_en) len_rd_q <= len_mem[bucket_q];
  end

  // Entry memories
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      key_mem[slot_wr_addr] <= key_q;
      val_mem[slot_wr_addr] <= val_q;
    end
    if (slot_rd_en) begin
      key_rd_q <= key_mem[slot_rd_addr];
      val_rd_q <= val_mem[slot_rd_addr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

endmodule

// File: src/cht_checker.sv
// ----------------------------------------------------------------------------
// cht_checker: port-level checks of the chained hash table
// Watches the stream ports and flags result or handshake slips.
// ----------------------------------------------------------------------------
module cht_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [31:0]               m_axis_tdata,
  input logic [1:0]                m_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready
);
  import cht_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Keep a stalled result unchanged
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Zero value unless a key was found
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_FOUND |-> m_axis_tdata == '0)
    else $error("value set on a result without a match");

  // One request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while one is in progress");

endmodule

bind chained_hash_table_top cht_checker u_cht_checker (.*);

// File: test/chained_hash_table_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_top_test: self-checking bench for the chained hash table
// Drives insert and search requests on the input stream and predicts every
// result with a software copy of the buckets and chains. Each returned result
// is compared with the oldest outstanding prediction. The run covers directed
// corner cases, several bucket counts with random traffic, and a long output
// stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module chained_hash_table_top_test;
  import cht_pkg::*;

  localparam int unsigned TB_BUCKETS  = MAX_BUCKETS_DEF;
  localparam int unsigned TB_DEPTH    = CHAIN_DEPTH_DEF;
  localparam int unsigned SETTLE_CYC  = 40;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYC    = 400;
  localparam int unsigned REPORT_CAP  = 100;

  typedef struct packed {
    cht_status_e      status;
    logic [VAL_W-1:0] value;
  } lookup_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic [63:0]       s_axis_tdata;
  logic              s_axis_tuser;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;

  // Software copy of the table
  logic [KEY_W-1:0]  slot_key [TB_BUCKETS*TB_DEPTH];
  logic [VAL_W-1:0]  slot_val [TB_BUCKETS*TB_DEPTH];
  int unsigned       chain_len [TB_BUCKETS] = '{default: 0};
  logic [CFG_W-1:0]  bucket_cfg = BUCKET_COUNT_RST;

  lookup_result_t    pending_lookups [$];
  logic [KEY_W-1:0]  issued_keys [$];
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       hold_cycles = 0;
  bit                src_idle = 1'b0;
  bit                sink_idle = 1'b0;

  chained_hash_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one request to the software table and return its result
  function automatic lookup_result_t predict_lookup(input cht_action_e act,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [VAL_W-1:0] val);
    int unsigned    nb;
    int unsigned    b;
    int unsigned    len;
    int unsigned    j;
    lookup_result_t r;
    if (bucket_cfg == '0) nb = 1;
    else if (bucket_cfg > TB_BUCKETS) nb = TB_BUCKETS;
    else nb = bucket_cfg;
    b = {1'b0, key} % nb;
    len = (chain_len[b] > TB_DEPTH) ? TB_DEPTH : chain_len[b];
    r.value = '0;
    if (act == ACT_INSERT) begin
      if (len >= TB_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot_key[b*TB_DEPTH+len] = key;
        slot_val[b*TB_DEPTH+len] = val;
        chain_len[b] = len + 1;
        r.status = ST_INSERTED;
      end
    end else begin
      // oldest matching entry wins
      r.status = ST_NOT_FOUND;
      for (j = 0; j < len && r.status != ST_FOUND; j++) begin
        if (slot_key[b*TB_DEPTH+j] == key) begin
          r.status = ST_FOUND;
          r.value = slot_val[b*TB_DEPTH+j];
        end
      end
    end
    return r;
  endfunction

  // Compare one returned result with the oldest prediction
  task automatic check_result();
    lookup_result_t want;
    if (pending_lookups.size() == 0) begin
      if (mismatch_count < REPORT_CAP)
        $error("result with no request outstanding: status %0d found_value 0x%08h",
               m_axis_tuser, m_axis_tdata);
      mismatch_count++;
    end else begin
      want = pending_lookups.pop_front();
      if (m_axis_tuser !== want.status) begin
        if (mismatch_count < REPORT_CAP)
          $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
        mismatch_count++;
      end
      if (m_axis_tdata !== want.value) begin
        if (mismatch_count < REPORT_CAP)
          $error("found_value: expected 0x%08h, actual 0x%08h", want.value, m_axis_tdata);
        mismatch_count++;
      end
    end
  endtask

  // Monitor: check results, predict accepted requests, track the register
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_result();
    if (s_axis_tvalid && s_axis_tready)
      pending_lookups.push_back(predict_lookup(cht_action_e'(s_axis_tuser),
                                               s_axis_tdata[KEY_W-1:0],
                                               s_axis_tdata[KEY_W+VAL_W-1:KEY_W]));
    if (cfg_we_i) bucket_cfg = cfg_wdata_i;
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("chained_hash_table_top_test: done, errors");
      $finish;
    end
  end

  // Result sink: random gap per result when idling is on, plus a long hold when requested
  initial begin : result_sink
    int unsigned gap;
    m_axis_tready = 1'b0;
    forever begin
      gap = sink_idle ? $urandom_range(0, 12) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      while (hold_cycles > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offer one request, after a random gap when idling is on, and hold it until taken
  task automatic send_request(input cht_action_e act, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 12) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {1'b0, val, key};
    if (act == ACT_INSERT) issued_keys.push_back(key);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(input logic [CFG_W-1:0] count);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    if ($urandom_range(0, 1)) return KEY_W'($urandom);
    return KEY_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [VAL_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly searches of keys already issued, some inserts, some stray keys
  task automatic issue_random_request();
    int unsigned      pick;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      if (issued_keys.size() > 0 && $urandom_range(0, 3) == 0)
        key = issued_keys[$urandom_range(0, issued_keys.size()-1)];
      else
        key = fresh_key();
      send_request(ACT_INSERT, key, random_word());
    end else if (pick < 85 && issued_keys.size() > 0) begin
      send_request(ACT_SEARCH, issued_keys[$urandom_range(0, issued_keys.size()-1)],
                   random_word());
    end else begin
      send_request(ACT_SEARCH, fresh_key(), random_word());
    end
  endtask

  // Field extremes, both operations, duplicates and a full chain at reset count
  task automatic test_directed_ops();
    send_request(ACT_INSERT, '0, '0);
    send_request(ACT_INSERT, '1, '1);
    send_request(ACT_SEARCH, '0, '0);
    send_request(ACT_SEARCH, '1, '0);
    send_request(ACT_SEARCH, KEY_W'(10), '0);
    // duplicate key: the older entry must be returned
    send_request(ACT_INSERT, KEY_W'(10), 32'hA5A5_A5A5);
    send_request(ACT_INSERT, '0, 32'h1234_5678);
    send_request(ACT_SEARCH, '0, '1);
    send_request(ACT_SEARCH, KEY_W'(10), '1);
    // fill one chain, then overflow it
    for (int i = 0; i <= TB_DEPTH; i++)
      send_request(ACT_INSERT, KEY_W'(3 + 10*i), 32'h5A5A_0000 | i);
    send_request(ACT_SEARCH, KEY_W'(3 + 10*(TB_DEPTH-1)), '0);
  endtask

  // Zero and oversized counts, and entries left behind by a count change
  task automatic test_count_extremes();
    write_bucket_count('0);
    send_request(ACT_SEARCH, KEY_W'(3), '0);
    send_request(ACT_SEARCH, '0, '0);
    write_bucket_count('1);
    send_request(ACT_SEARCH, KEY_W'(13), '0);
    send_request(ACT_INSERT, KEY_W'(31), 32'hC0DE_0031);
    write_bucket_count(CFG_W'(TB_BUCKETS));
    send_request(ACT_SEARCH, KEY_W'(31), '0);
  endtask

  // Random traffic over a sweep of bucket counts
  task automatic test_random_traffic();
    logic [CFG_W-1:0] counts [10] = '{5'd1, 5'd3, 5'd16, 5'd0, 5'd7,
                                      5'd31, 5'd12, 5'd17, 5'd5, 5'd10};
    foreach (counts[p]) begin
      write_bucket_count(counts[p]);
      for (int n = 0; n < 108; n++) begin
        // redraw idling now and then so that quiet stretches appear too
        if (n % 18 == 0) begin
          src_idle  = ($urandom_range(0, 3) != 0);
          sink_idle = ($urandom_range(0, 3) != 0);
        end
        issue_random_request();
      end
    end
  endtask

  // Hold the output for a long stretch while requests keep coming
  task automatic test_backpressure();
    write_bucket_count(CFG_W'(9));
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_cycles = HOLD_CYC;
    repeat (30) issue_random_request();
    sink_idle = 1'b1;
  endtask

  initial begin : test_sequence
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_ops();
    test_count_extremes();
    test_random_traffic();
    test_backpressure();
    wait_drained();

    if (pending_lookups.size() != 0) begin
      $error("%0d results never arrived", pending_lookups.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("chained_hash_table_top_test: done, clean");
    else
      $display("chained_hash_table_top_test: done, errors");
    $finish;
  end

endmodule

// File: sim.f
src/cht_pkg.sv
src/cht_mod.sv
src/chained_hash_table_top.sv
src/cht_checker.sv
test/chained_hash_table_top_test.sv
